@@ sv/rssi_proximity_tracker_top_assert.svh @@
// ----------------------------------------------------------------------------
// rssi_proximity_tracker_top_assert.svh
// Assertion macros used by the proximity tracker top level.
// ----------------------------------------------------------------------------
`ifndef RSSI_PROXIMITY_TRACKER_TOP_ASSERT_SVH
`define RSSI_PROXIMITY_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rpt_pkg.sv @@
// ----------------------------------------------------------------------------
// rpt_pkg
// Types, constants and the distance table of the RSSI proximity tracker.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // Field widths.
    localparam int RSSI_W = 8;
    localparam int PCT_W  = 7;
    localparam int CNT_W  = 16;
    localparam int THR_W  = 7;
    localparam int TRD_W  = RSSI_W + 1;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_NEAR  = 2'd0;
    localparam logic [1:0] REG_MID   = 2'd1;
    localparam logic [1:0] REG_TREND = 2'd2;

    localparam logic [THR_W-1:0] NEAR_RST  = 7'd70;
    localparam logic [THR_W-1:0] MID_RST   = 7'd38;
    localparam logic [THR_W-1:0] TREND_RST = 7'd4;

    // Proximity classes.
    localparam logic [1:0] PROX_SEARCH = 2'd0;
    localparam logic [1:0] PROX_FAR    = 2'd1;
    localparam logic [1:0] PROX_MEDIUM = 2'd2;
    localparam logic [1:0] PROX_NEAR   = 2'd3;

    // Trend classes.
    localparam logic [1:0] TRD_SEARCH = 2'd0;
    localparam logic [1:0] TRD_APPR   = 2'd1;
    localparam logic [1:0] TRD_LEAVE  = 2'd2;
    localparam logic [1:0] TRD_STABLE = 2'd3;

    typedef logic signed [RSSI_W-1:0] t_rssi;
    typedef logic signed [TRD_W-1:0]  t_trend;

    // Signal levels in dBm.
    localparam t_rssi RSSI_FLOOR = -8'sd127;
    localparam t_rssi RSSI_WEAK  = -8'sd120;
    localparam t_rssi LVL_LOW    = -8'sd100;
    localparam t_rssi LVL_HIGH   = -8'sd35;
    localparam t_rssi MISS_TREND = -8'sd8;
    localparam t_rssi RSSI_ZERO  = 8'sd0;

    localparam t_trend LVL_OFFSET = 9'sd100;
    localparam t_trend TRD_MAX    = 9'sd127;
    localparam t_trend TRD_MIN    = -9'sd127;

    // Level scaling: (x * 100) / 65 computed as (x * 403300) >> 18, exact for x < 65.
    localparam int RECIP_W   = 19;
    localparam int LVL_SHIFT = 18;
    localparam logic [RECIP_W-1:0] LVL_RECIP = 19'd403300;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0]   DIST_ONE  = 7'd1;

    // Rounded 10^((-59 - rssi) / 23), 1..99 up to 120 then 0, indexed by -rssi.
    localparam logic [PCT_W-1:0] DIST_TABLE [128] = '{
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,
        7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd6,  7'd7,  7'd7,
        7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd14, 7'd15, 7'd16,
        7'd18, 7'd20, 7'd22, 7'd25, 7'd27, 7'd30, 7'd33, 7'd37,
        7'd41, 7'd45, 7'd50, 7'd55, 7'd61, 7'd67, 7'd74, 7'd82,
        7'd90, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

    typedef struct packed {
        logic  restart;
        logic  found;
        t_rssi rssi;
    } t_item;

    typedef struct packed {
        t_rssi            held;
        t_rssi            peak;
        logic [CNT_W-1:0] cnt;
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0] near_thr;
        logic [THR_W-1:0] mid_thr;
        logic [THR_W-1:0] trend_thr;
    } t_cfg;

    typedef struct packed {
        logic             seen;
        t_rssi            current_rssi;
        logic [PCT_W-1:0] level_pct;
        logic [1:0]       proximity;
        t_rssi            trend_db;
        logic [1:0]       trend_class;
        t_rssi            peak_rssi;
        logic [PCT_W-1:0] distance_m;
        logic [CNT_W-1:0] pass_count;
    } t_result;

endpackage

@@ sv/rpt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rpt_cfg_regs
// APB-style register file holding the three classification thresholds.
// ----------------------------------------------------------------------------
module rpt_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpt_pkg::ADDR_W-1:0] paddr,
    input  logic [rpt_pkg::DATA_W-1:0] pwdata,
    output logic [rpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rpt_pkg::t_cfg              o_cfg
);
    import rpt_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; each register keeps the low seven bits of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_thr  <= NEAR_RST;
            r_cfg.mid_thr   <= MID_RST;
            r_cfg.trend_thr <= TREND_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NEAR:  r_cfg.near_thr  <= pwdata[THR_W-1:0];
                REG_MID:   r_cfg.mid_thr   <= pwdata[THR_W-1:0];
                REG_TREND: r_cfg.trend_thr <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data mux; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_NEAR:  prdata = {{(DATA_W-THR_W){1'b0}}, r_cfg.near_thr};
            REG_MID:   prdata = {{(DATA_W-THR_W){1'b0}}, r_cfg.mid_thr};
            REG_TREND: prdata = {{(DATA_W-THR_W){1'b0}}, r_cfg.trend_thr};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/rpt_eval.sv @@
// ----------------------------------------------------------------------------
// rpt_eval
// Combinational evaluation of one scan pass: next tracking state and result.
// ----------------------------------------------------------------------------
module rpt_eval (
    input  rpt_pkg::t_item   i_item,
    input  rpt_pkg::t_state  i_state,
    input  rpt_pkg::t_cfg    i_cfg,
    output rpt_pkg::t_state  o_state,
    output rpt_pkg::t_result o_result
);
    import rpt_pkg::*;

    localparam int PROD_W = PCT_W + RECIP_W;

    t_state              base;
    t_rssi               rssi;
    t_rssi               prev;
    t_trend              diff;
    t_trend              trend;
    t_trend              thr;
    t_trend              lvl_off;
    logic [PROD_W-1:0]   lvl_prod;
    logic [PCT_W-1:0]    pct;
    logic [RSSI_W-1:0]   neg_rssi;
    logic [PCT_W-1:0]    dist_est;

    assign rssi = i_item.rssi;

    // Restart puts the state back to its reset values before the pass applies.
    always_comb begin
        if (i_item.restart) begin
            base.held = RSSI_FLOOR;
            base.peak = RSSI_FLOOR;
            base.cnt  = '0;
        end else begin
            base = i_state;
        end
    end

    assign prev = base.held;

    // Level percentage: offset into 1..64, then scaled by a reciprocal multiply.
    assign lvl_off  = {rssi[RSSI_W-1], rssi} + LVL_OFFSET;
    assign lvl_prod = PROD_W'(lvl_off[PCT_W-1:0]) * PROD_W'(LVL_RECIP);

    always_comb begin
        if (rssi <= LVL_LOW) begin
            pct = '0;
        end else if (rssi >= LVL_HIGH) begin
            pct = PCT_MAX;
        end else begin
            pct = lvl_prod[LVL_SHIFT +: PCT_W];
        end
    end

    // Distance estimate from the table, indexed by the magnitude of the RSSI.
    assign neg_rssi = RSSI_W'(-rssi);

    always_comb begin
        if (rssi < RSSI_WEAK) begin
            dist_est = '0;
        end else if (rssi >= RSSI_ZERO) begin
            dist_est = DIST_ONE;
        end else begin
            dist_est = DIST_TABLE[neg_rssi[PCT_W-1:0]];
        end
    end

    // Trend since the previous pass, zero after a miss, saturated to +/-127.
    assign diff = {rssi[RSSI_W-1], rssi} - {prev[RSSI_W-1], prev};
    assign thr  = {{(TRD_W-THR_W){1'b0}}, i_cfg.trend_thr};

    always_comb begin
        if (prev < RSSI_WEAK) begin
            trend = '0;
        end else if (diff > TRD_MAX) begin
            trend = TRD_MAX;
        end else if (diff < TRD_MIN) begin
            trend = TRD_MIN;
        end else begin
            trend = diff;
        end
    end

    // Next state and result fields.
    always_comb begin
        o_state.cnt  = base.cnt + 1'b1;
        o_state.held = RSSI_FLOOR;
        o_state.peak = base.peak;

        o_result.seen        = i_item.found;
        o_result.level_pct   = '0;
        o_result.proximity   = PROX_SEARCH;
        o_result.trend_db    = MISS_TREND;
        o_result.trend_class = TRD_SEARCH;
        o_result.distance_m  = '0;

        if (i_item.found) begin
            o_state.held = rssi;
            if ((base.peak < RSSI_WEAK) || (rssi > base.peak)) begin
                o_state.peak = rssi;
            end

            o_result.level_pct  = pct;
            o_result.distance_m = dist_est;
            o_result.trend_db   = trend[RSSI_W-1:0];

            if (pct >= i_cfg.near_thr) begin
                o_result.proximity = PROX_NEAR;
            end else if (pct >= i_cfg.mid_thr) begin
                o_result.proximity = PROX_MEDIUM;
            end else begin
                o_result.proximity = PROX_FAR;
            end

            if (trend >= thr) begin
                o_result.trend_class = TRD_APPR;
            end else if (trend <= -thr) begin
                o_result.trend_class = TRD_LEAVE;
            end else begin
                o_result.trend_class = TRD_STABLE;
            end
        end

        o_result.current_rssi = o_state.held;
        o_result.peak_rssi    = o_state.peak;
        o_result.pass_count   = o_state.cnt;
    end

endmodule

@@ sv/rssi_proximity_tracker_top.sv @@
// ----------------------------------------------------------------------------
// rssi_proximity_tracker_top
// Tracks one target's RSSI over scan passes and reports level, proximity,
// trend, peak, distance estimate and pass count for every pass.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_ready   i_restart, i_found, i_rssi
//   output   out        o_out_valid / i_out_ready o_seen .. o_pass_count
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// An accepted pass lands in the input register, is evaluated combinationally and
// is written to the result register together with the state update; a new pass
// is taken every cycle while the output is not stalled.
// A stalled output holds the result register; the input register still fills,
// and o_in_ready falls only when both registers hold items.
// Reset is synchronous and active low; it restores the thresholds and state.
// ----------------------------------------------------------------------------
`include "rssi_proximity_tracker_top_assert.svh"

module rssi_proximity_tracker_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Scan pass input
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_restart,
    input  logic                       i_found,
    input  logic signed [7:0]          i_rssi,
    // Result output
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_seen,
    output logic signed [7:0]          o_current_rssi,
    output logic [6:0]                 o_level_pct,
    output logic [1:0]                 o_proximity,
    output logic signed [7:0]          o_trend_db,
    output logic [1:0]                 o_trend_class,
    output logic signed [7:0]          o_peak_rssi,
    output logic [6:0]                 o_distance_m,
    output logic [15:0]                o_pass_count,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpt_pkg::ADDR_W-1:0] paddr,
    input  logic [rpt_pkg::DATA_W-1:0] pwdata,
    output logic [rpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rpt_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    load_out;
    logic    out_free;
    logic    in_take;

    // Configuration registers.
    rpt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Flow control between input register and result register.
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = r_item_valid && out_free;
    assign o_in_ready = !r_item_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.restart <= i_restart;
            r_item.found   <= i_found;
            r_item.rssi    <= i_rssi;
        end
    end

    // Pass evaluation.
    rpt_eval u_eval (
        .i_item   (r_item),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Tracking state, updated as each pass moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.held <= RSSI_FLOOR;
            r_state.peak <= RSSI_FLOOR;
            r_state.cnt  <= '0;
        end else if (load_out) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_seen         = r_res.seen;
    assign o_current_rssi = r_res.current_rssi;
    assign o_level_pct    = r_res.level_pct;
    assign o_proximity    = r_res.proximity;
    assign o_trend_db     = r_res.trend_db;
    assign o_trend_class  = r_res.trend_class;
    assign o_peak_rssi    = r_res.peak_rssi;
    assign o_distance_m   = r_res.distance_m;
    assign o_pass_count   = r_res.pass_count;

    // Assertions.
    `RPT_ASSERT_NXT(a_count_matches_state, load_out, o_pass_count == r_state.cnt, "pass count differs from state")
    `RPT_ASSERT_IMP(a_miss_fields_zero, o_out_valid && !o_seen, (o_level_pct == '0) && (o_distance_m == '0) && (o_proximity == PROX_SEARCH), "miss result has nonzero fields")
    `RPT_ASSERT_IMP(a_peak_not_below, o_out_valid && o_seen, o_peak_rssi >= o_current_rssi, "peak below current RSSI")
    `RPT_ASSERT_IMP(a_ready_low_only_full, !o_in_ready, r_item_valid && r_out_valid && !i_out_ready, "input stalled without a full pipeline")

endmodule

@@ sim/proximity_result_checker.sv @@
// ----------------------------------------------------------------------------
// proximity_result_checker
// Watches the scan and result channels of the RSSI proximity tracker, keeps
// its own copy of the tracking state and thresholds, predicts one report per
// accepted scan and compares every delivered report field by field.
// ----------------------------------------------------------------------------
module proximity_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Scan channel
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_restart,
    input  logic                       i_found,
    input  rpt_pkg::t_rssi             i_rssi,
    // Result channel
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_seen,
    input  rpt_pkg::t_rssi             i_current_rssi,
    input  logic [rpt_pkg::PCT_W-1:0]  i_level_pct,
    input  logic [1:0]                 i_proximity,
    input  rpt_pkg::t_rssi             i_trend_db,
    input  logic [1:0]                 i_trend_class,
    input  rpt_pkg::t_rssi             i_peak_rssi,
    input  logic [rpt_pkg::PCT_W-1:0]  i_distance_m,
    input  logic [rpt_pkg::CNT_W-1:0]  i_pass_count,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpt_pkg::ADDR_W-1:0] paddr,
    input  logic [rpt_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    // Status toward the testbench top
    output int                         o_mismatches,
    output int                         o_outstanding,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    // Signal levels in dBm and scaling of the level percentage.
    localparam int FLOOR_DBM      = -127;
    localparam int WEAK_DBM       = -120;
    localparam int LEVEL_ZERO_DBM = -100;
    localparam int LEVEL_FULL_DBM = -35;
    localparam int LEVEL_SPAN_DB  = 65;
    localparam int FULL_SCALE_PCT = 100;
    localparam int MISS_TREND_DB  = -8;
    localparam int TREND_LIMIT_DB = 127;
    localparam int PRINT_CAP      = 40;

    // Threshold values after reset.
    localparam logic [THR_W-1:0] NEAR_AT_RESET  = 7'd70;
    localparam logic [THR_W-1:0] MID_AT_RESET   = 7'd38;
    localparam logic [THR_W-1:0] TREND_AT_RESET = 7'd4;

    // Rounded 10^((-59 - rssi) / 23) in meters, 1..99 to loss 120 then 0, by loss -rssi.
    localparam int METERS_BY_LOSS [128] = '{
        1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,
        1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,
        1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,
        1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,
        2,  2,  2,  2,  2,  3,  3,  3,  4,  4,  4,  5,  5,  6,  7,  7,
        8,  9,  10, 11, 12, 14, 15, 16, 18, 20, 22, 25, 27, 30, 33, 37,
        41, 45, 50, 55, 61, 67, 74, 82, 90, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99, 99, 0,  0,  0,  0,  0,  0,  0
    };

    // Tracking state and thresholds as the block should hold them.
    t_rssi            tracked_rssi;
    t_rssi            strongest_rssi;
    logic [CNT_W-1:0] scans_since_restart;
    logic [THR_W-1:0] near_level;
    logic [THR_W-1:0] mid_level;
    logic [THR_W-1:0] trend_step;

    // Reports predicted for accepted scans, oldest first.
    t_result awaited_reports [$];

    // Applies one scan to the tracking state and returns the report it yields.
    function automatic t_result predict_proximity(input logic restart_f, input logic found_f,
                                                  input t_rssi rssi_f);
        t_result report;
        int      prev_dbm;
        int      now_dbm;
        int      delta;
        int      level;

        if (restart_f) begin
            tracked_rssi        = t_rssi'(FLOOR_DBM);
            strongest_rssi      = t_rssi'(FLOOR_DBM);
            scans_since_restart = '0;
        end
        scans_since_restart = scans_since_restart + 1'b1;
        prev_dbm = int'(tracked_rssi);
        now_dbm  = int'(rssi_f);
        report   = '0;
        report.seen = found_f;

        if (found_f) begin
            tracked_rssi = rssi_f;
            if (int'(strongest_rssi) < WEAK_DBM || now_dbm > int'(strongest_rssi)) begin
                strongest_rssi = rssi_f;
            end

            // The first hit after a miss or restart has no trend to report.
            delta = (prev_dbm < WEAK_DBM) ? 0 : now_dbm - prev_dbm;
            if (delta > TREND_LIMIT_DB) delta = TREND_LIMIT_DB;
            if (delta < -TREND_LIMIT_DB) delta = -TREND_LIMIT_DB;

            if (now_dbm <= LEVEL_ZERO_DBM) begin
                level = 0;
            end else if (now_dbm >= LEVEL_FULL_DBM) begin
                level = FULL_SCALE_PCT;
            end else begin
                level = ((now_dbm - LEVEL_ZERO_DBM) * FULL_SCALE_PCT) / LEVEL_SPAN_DB;
            end
            report.level_pct = level[PCT_W-1:0];

            if (level >= int'(near_level)) begin
                report.proximity = PROX_NEAR;
            end else if (level >= int'(mid_level)) begin
                report.proximity = PROX_MEDIUM;
            end else begin
                report.proximity = PROX_FAR;
            end

            if (delta >= int'(trend_step)) begin
                report.trend_class = TRD_APPR;
            end else if (delta <= -int'(trend_step)) begin
                report.trend_class = TRD_LEAVE;
            end else begin
                report.trend_class = TRD_STABLE;
            end

            if (now_dbm < WEAK_DBM) begin
                report.distance_m = '0;
            end else if (now_dbm >= 0) begin
                report.distance_m = 7'd1;
            end else begin
                report.distance_m = METERS_BY_LOSS[-now_dbm][PCT_W-1:0];
            end
        end else begin
            // A miss drops the held level and forces a falling trend.
            tracked_rssi       = t_rssi'(FLOOR_DBM);
            delta              = MISS_TREND_DB;
            report.proximity   = PROX_SEARCH;
            report.trend_class = TRD_SEARCH;
        end

        report.current_rssi = tracked_rssi;
        report.trend_db     = t_rssi'(delta);
        report.peak_rssi    = strongest_rssi;
        report.pass_count   = scans_since_restart;
        return report;
    endfunction

    // Prints one line per mismatch (up to a cap) and counts it.
    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        o_mismatches++;
        if (o_mismatches <= PRINT_CAP) begin
            $display("%0t ns: report %0d, %s is %0d, expected %0d",
                     $time, o_checked, what, got_v, want_v);
        end
    endtask

    task automatic check_field(input string what, input int got_v, input int want_v);
        if (got_v != want_v) report_mismatch(what, got_v, want_v);
    endtask

    // Every rising edge: follow register writes, check delivered reports, then
    // predict the report of a newly accepted scan.
    always @(posedge i_clk) begin : monitor
        t_result want;

        if (!i_rst_n) begin
            tracked_rssi        = t_rssi'(FLOOR_DBM);
            strongest_rssi      = t_rssi'(FLOOR_DBM);
            scans_since_restart = '0;
            near_level          = NEAR_AT_RESET;
            mid_level           = MID_AT_RESET;
            trend_step          = TREND_AT_RESET;
            awaited_reports.delete();
            o_mismatches        = 0;
            o_checked           = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_NEAR:  near_level = pwdata[THR_W-1:0];
                    REG_MID:   mid_level  = pwdata[THR_W-1:0];
                    REG_TREND: trend_step = pwdata[THR_W-1:0];
                    default:   ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (awaited_reports.size() == 0) begin
                    report_mismatch("report with no scan outstanding", 1, 0);
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("seen", int'(i_seen), int'(want.seen));
                    check_field("current_rssi", int'(i_current_rssi),
                                int'(want.current_rssi));
                    check_field("level_pct", int'(i_level_pct), int'(want.level_pct));
                    check_field("proximity", int'(i_proximity), int'(want.proximity));
                    check_field("trend_db", int'(i_trend_db), int'(want.trend_db));
                    check_field("trend_class", int'(i_trend_class), int'(want.trend_class));
                    check_field("peak_rssi", int'(i_peak_rssi), int'(want.peak_rssi));
                    check_field("distance_m", int'(i_distance_m), int'(want.distance_m));
                    check_field("pass_count", int'(i_pass_count), int'(want.pass_count));
                end
            end

            if (i_in_valid && i_in_ready) begin
                awaited_reports.push_back(predict_proximity(i_restart, i_found, i_rssi));
            end
        end
        o_outstanding = awaited_reports.size();
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the RSSI proximity tracker with directed and random scan sequences
// under several threshold settings, with random gaps and stalls on both
// channels and one long output stall. A checker module beside the block
// predicts and compares every report.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int PHASE_COUNT      = 7;
    localparam int RANDOM_PHASE     = 5;
    localparam int PRESSURE_PHASE   = 2;
    localparam int SCANS_PER_PHASE  = 160;
    localparam int PRESSURE_SCANS   = 24;
    localparam int PRESSURE_HOLD    = 80;
    localparam int SETTLE_CYCLES    = 4;
    localparam int MAX_THRESHOLD    = 127;

    // Threshold settings per phase; the random phase draws its own.
    localparam int NEAR_PLAN  [PHASE_COUNT] = '{0, 100, 127, 55, 30, 0, 70};
    localparam int MID_PLAN   [PHASE_COUNT] = '{0, 100, 100, 20, 60, 0, 38};
    localparam int TREND_PLAN [PHASE_COUNT] = '{0, 127, 1,   8,  2,  0, 4};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_restart   = 1'b0;
    logic              i_found     = 1'b0;
    t_rssi             i_rssi      = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_seen;
    t_rssi             o_current_rssi;
    logic [PCT_W-1:0]  o_level_pct;
    logic [1:0]        o_proximity;
    t_rssi             o_trend_db;
    logic [1:0]        o_trend_class;
    t_rssi             o_peak_rssi;
    logic [PCT_W-1:0]  o_distance_m;
    logic [CNT_W-1:0]  o_pass_count;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatches;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int scans_sent  = 0;
    int walk_dbm    = -60;
    bit idle_enable = 1'b0;
    bit hold_request = 1'b0;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    rssi_proximity_tracker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .i_found        (i_found),
        .i_rssi         (i_rssi),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_seen         (o_seen),
        .o_current_rssi (o_current_rssi),
        .o_level_pct    (o_level_pct),
        .o_proximity    (o_proximity),
        .o_trend_db     (o_trend_db),
        .o_trend_class  (o_trend_class),
        .o_peak_rssi    (o_peak_rssi),
        .o_distance_m   (o_distance_m),
        .o_pass_count   (o_pass_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    proximity_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .i_found        (i_found),
        .i_rssi         (i_rssi),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_seen         (o_seen),
        .i_current_rssi (o_current_rssi),
        .i_level_pct    (o_level_pct),
        .i_proximity    (o_proximity),
        .i_trend_db     (o_trend_db),
        .i_trend_class  (o_trend_class),
        .i_peak_rssi    (o_peak_rssi),
        .i_distance_m   (o_distance_m),
        .i_pass_count   (o_pass_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    // Watchdog on the total run length.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_drain
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                for (stall = 1; stall < PRESSURE_HOLD; stall++) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offers one scan, after an optional gap, and returns at the edge of its transfer.
    task automatic send_scan(input logic restart_f, input logic found_f, input t_rssi rssi_f);
        int gap;
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart_f;
        i_found    <= found_f;
        i_rssi     <= rssi_f;
        if (found_f) walk_dbm = int'(rssi_f);
        scans_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Mostly a target drifting around its last level, with misses, restarts,
    // jumps anywhere in range and the two extremes mixed in.
    task automatic send_random_scans(input int count, input bit allow_restart);
        logic restart_f;
        logic found_f;
        int   pick;
        int   level;
        for (int k = 0; k < count; k++) begin
            restart_f = allow_restart && ($urandom_range(0, 39) == 0);
            found_f   = ($urandom_range(0, 7) != 0);
            pick      = $urandom_range(0, 15);
            if (pick == 0) begin
                level = $urandom_range(0, 1) ? 0 : -127;
            end else if (pick < 4) begin
                level = -int'($urandom_range(0, 127));
            end else begin
                level = walk_dbm + int'($urandom_range(0, 16)) - 8;
                if (level > 0) level = 0;
                if (level < -127) level = -127;
            end
            send_scan(restart_f, found_f, t_rssi'(level));
        end
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_threshold(input logic [1:0] index, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drops valid and waits until every report has come back.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int near_v;
        int mid_v;
        int trend_v;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_enable = 1'b1;

        // Directed scans under the reset thresholds.
        send_scan(1'b1, 1'b1, 0);      // restart into a full-strength first hit
        send_scan(1'b0, 1'b1, -127);   // largest drop, too weak for a distance
        send_scan(1'b0, 1'b1, -121);
        send_scan(1'b0, 1'b1, -120);   // weakest level with a distance
        send_scan(1'b0, 1'b1, -100);   // level floor
        send_scan(1'b0, 1'b1, -99);
        send_scan(1'b0, 1'b1, -36);
        send_scan(1'b0, 1'b1, -35);    // level ceiling
        send_scan(1'b0, 1'b1, -59);
        send_scan(1'b0, 1'b1, -55);    // rise of exactly the trend threshold
        send_scan(1'b0, 1'b1, -58);    // small fall stays stable
        send_scan(1'b0, 1'b1, -62);    // fall of exactly the trend threshold
        send_scan(1'b0, 1'b1, -62);
        send_scan(1'b0, 1'b0, -40);    // miss
        send_scan(1'b0, 1'b0, 0);
        send_scan(1'b0, 1'b1, -80);    // first hit after a miss has no trend
        send_scan(1'b0, 1'b1, -75);    // medium boundary
        send_scan(1'b0, 1'b1, -54);    // near boundary
        send_scan(1'b0, 1'b1, -55);
        send_scan(1'b0, 1'b1, -76);
        send_scan(1'b1, 1'b1, -90);    // restart in the middle of tracking
        send_scan(1'b1, 1'b0, -1);     // restart on a miss
        send_scan(1'b0, 1'b1, -1);
        send_scan(1'b0, 1'b1, -126);
        send_scan(1'b0, 1'b1, -110);
        settle();

        // Random scans under each threshold setting.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == RANDOM_PHASE) begin
                near_v  = $urandom_range(0, 100);
                mid_v   = $urandom_range(0, 100);
                trend_v = $urandom_range(0, MAX_THRESHOLD);
            end else begin
                near_v  = NEAR_PLAN[phase];
                mid_v   = MID_PLAN[phase];
                trend_v = TREND_PLAN[phase];
            end
            write_threshold(REG_NEAR, near_v);
            write_threshold(REG_MID, mid_v);
            write_threshold(REG_TREND, trend_v);

            // The last setting runs with both sides always ready.
            if (phase == PHASE_COUNT - 1) idle_enable = 1'b0;

            // Hold the result side while scans keep coming, so the block fills.
            if (phase == PRESSURE_PHASE) begin
                idle_enable  = 1'b0;
                hold_request = 1'b1;
                send_random_scans(PRESSURE_SCANS, 1'b1);
                idle_enable  = 1'b1;
            end

            send_random_scans(SCANS_PER_PHASE, 1'b1);
            settle();
        end

        $display("Drove %0d scans over %0d threshold settings, with random idling on",
                 scans_sent, PHASE_COUNT + 1);
        $display("both sides and one long result stall; %0d reports compared, %0d mismatches.",
                 checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
